@@ rtl/sqbl_pkg.sv @@
// sqbl_pkg: shared types, codes and byte classification for the query lexer
// no dependencies; used by sqbl_step and search_query_byte_lexer
`default_nettype none

package sqbl_pkg;

    // result buffer sizing
    localparam int MAX_REC   = 4;
    localparam int REC_IDX_W = 2;
    localparam int REC_CNT_W = 3;

    // lexer mode
    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_STR   = 3'd2,
        MODE_QUOTE = 3'd3,
        MODE_SKIP  = 3'd4
    } lex_mode_t;

    // keyword prefix tracking
    localparam logic [2:0] KW_NONE = 3'd0;
    localparam logic [2:0] KW_AND  = 3'd1;
    localparam logic [2:0] KW_OR   = 3'd2;
    localparam logic [2:0] KW_NOT  = 3'd3;

    // record kinds
    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // token types
    localparam logic [3:0] TOK_BARE   = 4'd0;
    localparam logic [3:0] TOK_STRING = 4'd1;
    localparam logic [3:0] TOK_AND    = 4'd2;
    localparam logic [3:0] TOK_OR     = 4'd3;
    localparam logic [3:0] TOK_NOT    = 4'd4;
    localparam logic [3:0] TOK_STAR   = 4'd5;
    localparam logic [3:0] TOK_PLUS   = 4'd6;
    localparam logic [3:0] TOK_COMMA  = 4'd7;
    localparam logic [3:0] TOK_COLON  = 4'd8;
    localparam logic [3:0] TOK_MINUS  = 4'd9;
    localparam logic [3:0] TOK_CARET  = 4'd10;
    localparam logic [3:0] TOK_LPAREN = 4'd11;
    localparam logic [3:0] TOK_RPAREN = 4'd12;
    localparam logic [3:0] TOK_LBRACE = 4'd13;
    localparam logic [3:0] TOK_RBRACE = 4'd14;
    localparam logic [3:0] TOK_END    = 4'd15;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_UNCLOSED = 2'd1;
    localparam logic [1:0] ERR_QUOTING  = 2'd2;

    // special bytes
    localparam logic [7:0] BYTE_QUOTE = 8'h22;
    localparam logic [7:0] BYTE_SUB   = 8'h1A;
    localparam logic [7:0] BYTE_HIGH  = 8'h80;
    localparam logic [2:0] LEN_MAX    = 3'd7;

    typedef struct packed {
        lex_mode_t  mode;
        logic [2:0] kw;
        logic [2:0] len;
    } lex_state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ttype;
        logic [7:0] text;
        logic [1:0] err;
        logic       done;
    } rec_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_word_byte(input logic [7:0] b);
        return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
               ((b >= 8'h61) && (b <= 8'h7A)) || (b == 8'h5F) ||
               (b == BYTE_SUB) || (b >= BYTE_HIGH);
    endfunction

    // operator token type, TOK_BARE when not an operator
    function automatic logic [3:0] op_type(input logic [7:0] b);
        logic [3:0] t;
        case (b)
            8'h2A:   t = TOK_STAR;
            8'h2B:   t = TOK_PLUS;
            8'h2C:   t = TOK_COMMA;
            8'h3A:   t = TOK_COLON;
            8'h2D:   t = TOK_MINUS;
            8'h5E:   t = TOK_CARET;
            8'h28:   t = TOK_LPAREN;
            8'h29:   t = TOK_RPAREN;
            8'h7B:   t = TOK_LBRACE;
            8'h7D:   t = TOK_RBRACE;
            default: t = TOK_BARE;
        endcase
        return t;
    endfunction

    // add one byte to a bareword, tracking keyword prefix and length
    function automatic lex_state_t word_step(input lex_state_t st, input logic [7:0] b);
        lex_state_t ns;
        logic [7:0] want;
        logic       have;
        ns      = st;
        ns.mode = MODE_WORD;
        want    = 8'h00;
        have    = 1'b0;
        case (st.kw)
            KW_AND: begin
                have = (st.len == 3'd1) || (st.len == 3'd2);
                want = (st.len == 3'd1) ? 8'h4E : 8'h44;
            end
            KW_OR: begin
                have = (st.len == 3'd1);
                want = 8'h52;
            end
            KW_NOT: begin
                have = (st.len == 3'd1) || (st.len == 3'd2);
                want = (st.len == 3'd1) ? 8'h4F : 8'h54;
            end
            default: begin
                have = 1'b0;
                want = 8'h00;
            end
        endcase
        if (st.len == 3'd0) begin
            ns.kw = (b == 8'h41) ? KW_AND : (b == 8'h4F) ? KW_OR :
                    (b == 8'h4E) ? KW_NOT : KW_NONE;
        end else if (!(have && (b == want))) begin
            ns.kw = KW_NONE;
        end
        if (st.len != LEN_MAX) begin
            ns.len = st.len + 3'd1;
        end
        return ns;
    endfunction

    // token type of a completed bareword
    function automatic logic [3:0] word_type(input lex_state_t st);
        logic [3:0] t;
        t = TOK_BARE;
        if ((st.kw == KW_AND) && (st.len == 3'd3)) t = TOK_AND;
        if ((st.kw == KW_OR)  && (st.len == 3'd2)) t = TOK_OR;
        if ((st.kw == KW_NOT) && (st.len == 3'd3)) t = TOK_NOT;
        return t;
    endfunction

    function automatic rec_t make_rec(input logic [1:0] kind, input logic [3:0] ttype,
                                      input logic [7:0] text, input logic [1:0] err,
                                      input logic done);
        rec_t r;
        r.kind  = kind;
        r.ttype = ttype;
        r.text  = text;
        r.err   = err;
        r.done  = done;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sqbl_step.sv @@
// sqbl_step: lexer step for one byte, next state and up to four result records
// depends on sqbl_pkg
`default_nettype none

module sqbl_step (
    input  wire sqbl_pkg::lex_state_t                   cur_state,
    input  wire logic [7:0]                             in_byte,
    input  wire logic                                   end_of_query,
    output sqbl_pkg::lex_state_t                        next_state,
    output sqbl_pkg::rec_t                              recs [sqbl_pkg::MAX_REC],
    output logic [sqbl_pkg::REC_CNT_W-1:0]              rec_cnt
);

    sqbl_pkg::lex_state_t zero_state;
    sqbl_pkg::lex_state_t fresh_state;
    sqbl_pkg::lex_state_t mid_state;
    sqbl_pkg::rec_t       rec_a, rec_b, rec_c, rec_d;
    logic                 va, vb, vc, vd;
    logic                 b_space, b_quote, b_word, fresh_path;
    logic [3:0]           b_op;

    // byte classification
    assign b_space = sqbl_pkg::is_space(in_byte);
    assign b_quote = (in_byte == sqbl_pkg::BYTE_QUOTE);
    assign b_word  = sqbl_pkg::is_word_byte(in_byte);
    assign b_op    = sqbl_pkg::op_type(in_byte);

    assign zero_state = '{mode: sqbl_pkg::MODE_IDLE, kw: sqbl_pkg::KW_NONE, len: 3'd0};

    // byte lexed from idle, also after a token is closed by it
    assign fresh_path = (cur_state.mode == sqbl_pkg::MODE_IDLE) ||
                        ((cur_state.mode == sqbl_pkg::MODE_WORD) && !b_word) ||
                        ((cur_state.mode == sqbl_pkg::MODE_QUOTE) && !b_quote);

    // state reached by a fresh byte
    always_comb begin
        fresh_state = zero_state;
        if (b_space) begin
            fresh_state = zero_state;
        end else if (b_quote) begin
            fresh_state.mode = sqbl_pkg::MODE_STR;
        end else if (b_word) begin
            fresh_state = sqbl_pkg::word_step(zero_state, in_byte);
        end else if (b_op != sqbl_pkg::TOK_BARE) begin
            fresh_state = zero_state;
        end else begin
            fresh_state.mode = sqbl_pkg::MODE_SKIP;
        end
    end

    // next state
    always_comb begin
        mid_state = cur_state;
        case (cur_state.mode)
            sqbl_pkg::MODE_IDLE: begin
                mid_state = fresh_state;
            end
            sqbl_pkg::MODE_WORD: begin
                mid_state = b_word ? sqbl_pkg::word_step(cur_state, in_byte) : fresh_state;
            end
            sqbl_pkg::MODE_STR: begin
                mid_state.mode = b_quote ? sqbl_pkg::MODE_QUOTE : sqbl_pkg::MODE_STR;
            end
            sqbl_pkg::MODE_QUOTE: begin
                if (b_quote) begin
                    mid_state.mode = sqbl_pkg::MODE_STR;
                end else begin
                    mid_state = fresh_state;
                end
            end
            default: begin
                mid_state.mode = sqbl_pkg::MODE_SKIP;
            end
        endcase
        next_state = end_of_query ? zero_state : mid_state;
    end

    // result records in emission order
    always_comb begin
        va    = 1'b0;
        vb    = 1'b0;
        vc    = 1'b0;
        vd    = 1'b0;
        rec_a = '0;
        rec_b = '0;
        rec_c = '0;
        rec_d = '0;

        // close of the token that this byte ends
        if ((cur_state.mode == sqbl_pkg::MODE_WORD) && !b_word) begin
            va    = 1'b1;
            rec_a = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::word_type(cur_state),
                                       8'h00, sqbl_pkg::ERR_NONE, 1'b0);
        end else if ((cur_state.mode == sqbl_pkg::MODE_QUOTE) && !b_quote) begin
            va    = 1'b1;
            rec_a = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STRING,
                                       8'h00, sqbl_pkg::ERR_NONE, 1'b0);
        end

        // record of the byte itself
        if (fresh_path) begin
            if (b_space || b_quote) begin
                vb = 1'b0;
            end else if (b_word) begin
                vb    = 1'b1;
                rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_BARE,
                                           in_byte, sqbl_pkg::ERR_NONE, 1'b0);
            end else if (b_op != sqbl_pkg::TOK_BARE) begin
                vb    = 1'b1;
                rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE, b_op,
                                           8'h00, sqbl_pkg::ERR_NONE, 1'b0);
            end else begin
                vb    = 1'b1;
                rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_ERROR, sqbl_pkg::TOK_BARE,
                                           8'h00, sqbl_pkg::ERR_QUOTING, 1'b1);
            end
        end else if (cur_state.mode == sqbl_pkg::MODE_WORD) begin
            vb    = 1'b1;
            rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_BARE,
                                       in_byte, sqbl_pkg::ERR_NONE, 1'b0);
        end else if ((cur_state.mode == sqbl_pkg::MODE_STR) && !b_quote) begin
            vb    = 1'b1;
            rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_STRING,
                                       in_byte, sqbl_pkg::ERR_NONE, 1'b0);
        end else if (cur_state.mode == sqbl_pkg::MODE_QUOTE) begin
            vb    = 1'b1;
            rec_b = sqbl_pkg::make_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_STRING,
                                       sqbl_pkg::BYTE_QUOTE, sqbl_pkg::ERR_NONE, 1'b0);
        end

        // end of query outside skip mode: close open token, then end token or unclosed error
        if (end_of_query && (cur_state.mode != sqbl_pkg::MODE_SKIP) &&
            (mid_state.mode != sqbl_pkg::MODE_SKIP)) begin
            vd = 1'b1;
            if (mid_state.mode == sqbl_pkg::MODE_STR) begin
                rec_d = sqbl_pkg::make_rec(sqbl_pkg::KIND_ERROR, sqbl_pkg::TOK_BARE,
                                           8'h00, sqbl_pkg::ERR_UNCLOSED, 1'b1);
            end else begin
                if (mid_state.mode == sqbl_pkg::MODE_WORD) begin
                    vc    = 1'b1;
                    rec_c = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE,
                                               sqbl_pkg::word_type(mid_state),
                                               8'h00, sqbl_pkg::ERR_NONE, 1'b0);
                end else if (mid_state.mode == sqbl_pkg::MODE_QUOTE) begin
                    vc    = 1'b1;
                    rec_c = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STRING,
                                               8'h00, sqbl_pkg::ERR_NONE, 1'b0);
                end
                rec_d = sqbl_pkg::make_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_END,
                                           8'h00, sqbl_pkg::ERR_NONE, 1'b1);
            end
        end
    end

    // pack valid records to the front
    always_comb begin
        logic [sqbl_pkg::REC_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < sqbl_pkg::MAX_REC; i++) begin
            recs[i] = '0;
        end
        if (va) begin
            recs[n[sqbl_pkg::REC_IDX_W-1:0]] = rec_a;
            n = n + 3'd1;
        end
        if (vb) begin
            recs[n[sqbl_pkg::REC_IDX_W-1:0]] = rec_b;
            n = n + 3'd1;
        end
        if (vc) begin
            recs[n[sqbl_pkg::REC_IDX_W-1:0]] = rec_c;
            n = n + 3'd1;
        end
        if (vd) begin
            recs[n[sqbl_pkg::REC_IDX_W-1:0]] = rec_d;
            n = n + 3'd1;
        end
        rec_cnt = n;
    end

endmodule

`default_nettype wire

@@ rtl/search_query_byte_lexer.sv @@
// search_query_byte_lexer: streaming query tokenizer, one byte per item
// latency: the first record of an item is valid the cycle after it is accepted
// throughput: one item per cycle while m_ready is high and each item gives at most one
//   record; an item that gives more (up to four) holds the buffer until all are read
// reset: aresetn synchronous active low, lexer idle and result buffer empty
// depends on sqbl_pkg and sqbl_step
`default_nettype none

module search_query_byte_lexer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_query,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_record_kind,
    output logic [3:0]      m_token_type,
    output logic [7:0]      m_text_byte,
    output logic [1:0]      m_error_code,
    output logic            m_run_last,
    output logic            m_query_done
);

    sqbl_pkg::lex_state_t                 state_reg;
    sqbl_pkg::lex_state_t                 state_next;
    sqbl_pkg::rec_t                       rec_reg [sqbl_pkg::MAX_REC];
    sqbl_pkg::rec_t                       rec_next [sqbl_pkg::MAX_REC];
    sqbl_pkg::rec_t                       cur_rec;
    logic [sqbl_pkg::REC_CNT_W-1:0]       cnt_reg;
    logic [sqbl_pkg::REC_CNT_W-1:0]       cnt_next;
    logic [sqbl_pkg::REC_IDX_W-1:0]       rd_reg;
    logic                                 in_take, out_take, last_rec;

    // one byte through the lexer
    sqbl_step u_step (
        .cur_state    (state_reg),
        .in_byte      (s_in_byte),
        .end_of_query (s_end_of_query),
        .next_state   (state_next),
        .recs         (rec_next),
        .rec_cnt      (cnt_next)
    );

    // handshakes: take a new item when the buffer is empty or empties this cycle
    assign m_valid  = (cnt_reg != '0);
    assign last_rec = ({1'b0, rd_reg} == (cnt_reg - 3'd1));
    assign out_take = m_valid && m_ready;
    assign s_ready  = !m_valid || (out_take && last_rec);
    assign in_take  = s_valid && s_ready;

    // lexer state and buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: sqbl_pkg::MODE_IDLE, kw: sqbl_pkg::KW_NONE, len: 3'd0};
            cnt_reg   <= '0;
            rd_reg    <= '0;
        end else if (in_take) begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rd_reg    <= '0;
        end else if (out_take) begin
            if (last_rec) begin
                cnt_reg <= '0;
                rd_reg  <= '0;
            end else begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    // record payload
    always_ff @(posedge aclk) begin
        if (in_take) begin
            for (int i = 0; i < sqbl_pkg::MAX_REC; i++) begin
                rec_reg[i] <= rec_next[i];
            end
        end
    end

    // output record
    assign cur_rec       = rec_reg[rd_reg];
    assign m_record_kind = cur_rec.kind;
    assign m_token_type  = cur_rec.ttype;
    assign m_text_byte   = cur_rec.text;
    assign m_error_code  = cur_rec.err;
    assign m_query_done  = cur_rec.done;
    assign m_run_last    = last_rec;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for search_query_byte_lexer, random gaps on both channels
// directed byte table first, then random, mostly well-formed queries checked against a local model
// depends on sqbl_pkg and the lexer rtl
`timescale 1ns / 100ps

module tb_top;

    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    // one expected or observed result record
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] ttype;
        logic [7:0] text;
        logic [1:0] err;
        logic       run_last;
        logic       done;
    } lex_rec_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       typed;
        lex_rec_t   rec;
    } dir_row_t;

    localparam lex_rec_t NO_REC = '0;
    localparam logic [7:0] OP_BYTES [10] = '{"*", "+", ",", ":", "-", "^", "(", ")", "{", "}"};
    localparam logic [7:0] WS_BYTES [4]  = '{8'h20, 8'h09, 8'h0A, 8'h0D};

    logic       aclk;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte      = 8'h00;
    logic       s_end_of_query = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [1:0] m_record_kind;
    logic [3:0] m_token_type;
    logic [7:0] m_text_byte;
    logic [1:0] m_error_code;
    logic       m_run_last;
    logic       m_query_done;

    search_query_byte_lexer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_query (s_end_of_query),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_record_kind  (m_record_kind),
        .m_token_type   (m_token_type),
        .m_text_byte    (m_text_byte),
        .m_error_code   (m_error_code),
        .m_run_last     (m_run_last),
        .m_query_done   (m_query_done)
    );

    // directed items: all operators, keywords, escaped quote, extremes, both errors
    dir_row_t dir_rows [29] = '{
        '{"*", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STAR,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"+", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_PLUS,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{",", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_COMMA,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{":", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_COLON,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"-", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_MINUS,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"^", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_CARET,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"(", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_LPAREN,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{")", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_RPAREN,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"{", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_LBRACE,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"}", 1'b0, 1'b1, '{sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_RBRACE,
                             8'h00, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{"A", 1'b0, 1'b0, NO_REC},
        '{"N", 1'b0, 1'b0, NO_REC},
        '{"D", 1'b0, 1'b0, NO_REC},
        '{" ", 1'b0, 1'b0, NO_REC},
        '{"O", 1'b0, 1'b0, NO_REC},
        '{"R", 1'b0, 1'b0, NO_REC},
        '{sqbl_pkg::BYTE_QUOTE, 1'b0, 1'b0, NO_REC},
        '{sqbl_pkg::BYTE_QUOTE, 1'b0, 1'b0, NO_REC},
        '{sqbl_pkg::BYTE_QUOTE, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b1, '{sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_STRING,
                               8'hFF, sqbl_pkg::ERR_NONE, 1'b1, 1'b0}},
        '{sqbl_pkg::BYTE_QUOTE, 1'b0, 1'b0, NO_REC},
        '{sqbl_pkg::BYTE_SUB, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, '{sqbl_pkg::KIND_ERROR, sqbl_pkg::TOK_BARE,
                               8'h00, sqbl_pkg::ERR_QUOTING, 1'b1, 1'b1}},
        '{8'h80, 1'b1, 1'b0, NO_REC},
        '{sqbl_pkg::BYTE_QUOTE, 1'b0, 1'b0, NO_REC},
        '{"x", 1'b1, 1'b0, NO_REC},
        '{"N", 1'b0, 1'b0, NO_REC},
        '{"O", 1'b0, 1'b0, NO_REC},
        '{"T", 1'b1, 1'b0, NO_REC}
    };

    // lexer model state
    sqbl_pkg::lex_mode_t lx_mode = sqbl_pkg::MODE_IDLE;
    logic [2:0]          lx_kw   = sqbl_pkg::KW_NONE;
    logic [2:0]          lx_len  = 3'd0;

    lex_rec_t step_recs[$];
    lex_rec_t token_recs_due[$];

    bit calm = 1'b0;
    int items_sent = 0;
    int queries_sent = 0;
    int records_checked = 0;
    int err_count = 0;
    int cycle_count = 0;
    int out_stall = 0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void add_rec(input logic [1:0] kind, input logic [3:0] tt,
                                    input logic [7:0] tx, input logic [1:0] er,
                                    input logic dn);
        lex_rec_t r;
        r = '{kind, tt, tx, er, 1'b0, dn};
        step_recs = {step_recs, r};
    endfunction

    function automatic logic word_char(input logic [7:0] b);
        return (b inside {["0":"9"], ["A":"Z"], ["a":"z"], "_", sqbl_pkg::BYTE_SUB}) ||
               (b >= sqbl_pkg::BYTE_HIGH);
    endfunction

    // extend the current bareword, keeping track of a possible keyword prefix
    function automatic void grow_word(input logic [7:0] b);
        logic ok;
        if (lx_len == 3'd0) begin
            lx_kw = (b == "A") ? sqbl_pkg::KW_AND : (b == "O") ? sqbl_pkg::KW_OR :
                    (b == "N") ? sqbl_pkg::KW_NOT : sqbl_pkg::KW_NONE;
        end else begin
            case (lx_kw)
                sqbl_pkg::KW_AND: ok = (lx_len == 3'd1 && b == "N") ||
                                       (lx_len == 3'd2 && b == "D");
                sqbl_pkg::KW_OR:  ok = (lx_len == 3'd1 && b == "R");
                sqbl_pkg::KW_NOT: ok = (lx_len == 3'd1 && b == "O") ||
                                       (lx_len == 3'd2 && b == "T");
                default:          ok = 1'b0;
            endcase
            if (!ok) lx_kw = sqbl_pkg::KW_NONE;
        end
        if (lx_len != 3'd7) lx_len = lx_len + 3'd1;
        add_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_BARE, b, sqbl_pkg::ERR_NONE, 1'b0);
    endfunction

    function automatic logic [3:0] word_token();
        if (lx_kw == sqbl_pkg::KW_AND && lx_len == 3'd3) return sqbl_pkg::TOK_AND;
        if (lx_kw == sqbl_pkg::KW_OR && lx_len == 3'd2) return sqbl_pkg::TOK_OR;
        if (lx_kw == sqbl_pkg::KW_NOT && lx_len == 3'd3) return sqbl_pkg::TOK_NOT;
        return sqbl_pkg::TOK_BARE;
    endfunction

    // lex a byte from the between-tokens state
    function automatic void lex_fresh(input logic [7:0] b);
        lx_mode = sqbl_pkg::MODE_IDLE;
        lx_kw   = sqbl_pkg::KW_NONE;
        lx_len  = 3'd0;
        case (b)
            8'h20, 8'h09, 8'h0A, 8'h0D: ;
            sqbl_pkg::BYTE_QUOTE: lx_mode = sqbl_pkg::MODE_STR;
            "*": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STAR, 8'h00, sqbl_pkg::ERR_NONE, 1'b0);
            "+": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_PLUS, 8'h00, sqbl_pkg::ERR_NONE, 1'b0);
            ",": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_COMMA, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            ":": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_COLON, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            "-": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_MINUS, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            "^": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_CARET, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            "(": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_LPAREN, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            ")": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_RPAREN, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            "{": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_LBRACE, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            "}": add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_RBRACE, 8'h00, sqbl_pkg::ERR_NONE,
                         1'b0);
            default: begin
                if (word_char(b)) begin
                    lx_mode = sqbl_pkg::MODE_WORD;
                    grow_word(b);
                end else begin
                    add_rec(sqbl_pkg::KIND_ERROR, sqbl_pkg::TOK_BARE, 8'h00,
                            sqbl_pkg::ERR_QUOTING, 1'b1);
                    lx_mode = sqbl_pkg::MODE_SKIP;
                end
            end
        endcase
    endfunction

    // records caused by one accepted byte, left in step_recs
    function automatic void lex_predict(input logic [7:0] b, input logic last);
        logic was_skip;
        step_recs.delete();
        was_skip = (lx_mode == sqbl_pkg::MODE_SKIP);
        case (lx_mode)
            sqbl_pkg::MODE_IDLE: lex_fresh(b);
            sqbl_pkg::MODE_WORD: begin
                if (word_char(b)) begin
                    grow_word(b);
                end else begin
                    add_rec(sqbl_pkg::KIND_DONE, word_token(), 8'h00, sqbl_pkg::ERR_NONE, 1'b0);
                    lex_fresh(b);
                end
            end
            sqbl_pkg::MODE_STR: begin
                if (b == sqbl_pkg::BYTE_QUOTE) lx_mode = sqbl_pkg::MODE_QUOTE;
                else add_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_STRING, b,
                             sqbl_pkg::ERR_NONE, 1'b0);
            end
            sqbl_pkg::MODE_QUOTE: begin
                if (b == sqbl_pkg::BYTE_QUOTE) begin
                    lx_mode = sqbl_pkg::MODE_STR;
                    add_rec(sqbl_pkg::KIND_TEXT, sqbl_pkg::TOK_STRING, b,
                            sqbl_pkg::ERR_NONE, 1'b0);
                end else begin
                    add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STRING, 8'h00,
                            sqbl_pkg::ERR_NONE, 1'b0);
                    lex_fresh(b);
                end
            end
            default: ;
        endcase
        // last byte closes the query
        if (last) begin
            if (!was_skip && lx_mode != sqbl_pkg::MODE_SKIP) begin
                if (lx_mode == sqbl_pkg::MODE_STR) begin
                    add_rec(sqbl_pkg::KIND_ERROR, sqbl_pkg::TOK_BARE, 8'h00,
                            sqbl_pkg::ERR_UNCLOSED, 1'b1);
                end else begin
                    if (lx_mode == sqbl_pkg::MODE_WORD)
                        add_rec(sqbl_pkg::KIND_DONE, word_token(), 8'h00,
                                sqbl_pkg::ERR_NONE, 1'b0);
                    else if (lx_mode == sqbl_pkg::MODE_QUOTE)
                        add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_STRING, 8'h00,
                                sqbl_pkg::ERR_NONE, 1'b0);
                    add_rec(sqbl_pkg::KIND_DONE, sqbl_pkg::TOK_END, 8'h00,
                            sqbl_pkg::ERR_NONE, 1'b1);
                end
            end
            lx_mode = sqbl_pkg::MODE_IDLE;
            lx_kw   = sqbl_pkg::KW_NONE;
            lx_len  = 3'd0;
        end
        if (step_recs.size() > 0) step_recs[step_recs.size() - 1].run_last = 1'b1;
    endfunction

    // offer one item after a random gap, predict once accepted
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input lex_rec_t typed_rec);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_in_byte      <= b;
        s_end_of_query <= last;
        do @(posedge aclk); while (!s_ready);
        lex_predict(b, last);
        if (typed) token_recs_due = {token_recs_due, typed_rec};
        else foreach (step_recs[i]) token_recs_due = {token_recs_due, step_recs[i]};
        items_sent++;
        if (last) queries_sent++;
    endtask

    // hold off the sender until every due record has come out
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (token_recs_due.size() > 0);
    endtask

    function automatic void push_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    endfunction

    function automatic logic [7:0] rand_word_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = 8'($urandom_range(8'h30, 8'h39));
            1: c = 8'($urandom_range(8'h41, 8'h5A));
            2: c = 8'($urandom_range(8'h61, 8'h7A));
            3: c = "_";
            4: c = sqbl_pkg::BYTE_SUB;
            default: c = 8'($urandom_range(8'h80, 8'hFF));
        endcase
        return c;
    endfunction

    // one random query: mostly well-formed tokens, some noise, rarely an open string
    task automatic run_query();
        logic [7:0] qbytes[$];
        logic [7:0] c;
        int ntok;
        int pick;
        int n;
        ntok = $urandom_range(1, 5);
        for (int t = 0; t < ntok; t++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                case ($urandom_range(0, 7))
                    0: push_text(qbytes, "AND");
                    1: push_text(qbytes, "OR");
                    2: push_text(qbytes, "NOT");
                    3: push_text(qbytes, "AN");
                    4: push_text(qbytes, "NOTE");
                    5: push_text(qbytes, "ORB");
                    default: begin
                        n = $urandom_range(1, 9);
                        repeat (n) qbytes = {qbytes, rand_word_char()};
                    end
                endcase
                if ($urandom_range(0, 1)) qbytes = {qbytes, 8'h20};
            end else if (pick < 50) begin
                qbytes = {qbytes, sqbl_pkg::BYTE_QUOTE};
                n = $urandom_range(0, 6);
                repeat (n) begin
                    c = 8'($urandom_range(0, 255));
                    qbytes = {qbytes, c};
                    if (c == sqbl_pkg::BYTE_QUOTE) qbytes = {qbytes, c};
                end
                if (!(t == ntok - 1 && $urandom_range(0, 9) == 0))
                    qbytes = {qbytes, sqbl_pkg::BYTE_QUOTE};
            end else if (pick < 72) begin
                qbytes = {qbytes, OP_BYTES[$urandom_range(0, 9)]};
            end else if (pick < 88) begin
                n = $urandom_range(1, 2);
                repeat (n) qbytes = {qbytes, WS_BYTES[$urandom_range(0, 3)]};
            end else begin
                qbytes = {qbytes, 8'($urandom_range(0, 255))};
            end
        end
        foreach (qbytes[i]) send_byte(qbytes[i], i == qbytes.size() - 1, 1'b0, NO_REC);
    endtask

    // result side: random stall after each accepted record
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            out_stall = 0;
        end else if (m_valid && m_ready) begin
            out_stall = calm ? 0 : $urandom_range(0, 10);
            m_ready   <= (out_stall == 0);
        end else if (!m_ready) begin
            if (out_stall > 1) begin
                out_stall--;
            end else begin
                out_stall = 0;
                m_ready   <= 1'b1;
            end
        end
    end

    // compare each accepted record with the oldest one due
    always @(posedge aclk) begin
        lex_rec_t got;
        lex_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_record_kind, m_token_type, m_text_byte, m_error_code,
                    m_run_last, m_query_done};
            if (token_recs_due.size() == 0) begin
                $display("%0t unexpected record kind=%0d type=%0d text=%02h err=%0d last=%0b done=%0b",
                         $time, got.kind, got.ttype, got.text, got.err, got.run_last, got.done);
                err_count++;
            end else begin
                want = token_recs_due.pop_front();
                records_checked++;
                if (got !== want) begin
                    $display("%0t mismatch expected kind=%0d type=%0d text=%02h err=%0d last=%0b done=%0b",
                             $time, want.kind, want.ttype, want.text, want.err, want.run_last,
                             want.done);
                    $display("%0t          actual   kind=%0d type=%0d text=%02h err=%0d last=%0b done=%0b",
                             $time, got.kind, got.ttype, got.text, got.err, got.run_last, got.done);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d records still due", cycle_count,
                     token_recs_due.size());
            $display("[search_query_byte_lexer] ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        int qidx;
        int dir_items;
        qidx = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                                        dir_rows[i].rec);
        dir_items = items_sent;
        drain();

        // random queries, with some back-to-back stretches and one full hold-off
        while (items_sent < dir_items + RANDOM_ITEMS) begin
            calm = (qidx % 7 == 3);
            run_query();
            if (qidx == 6) drain();
            qidx++;
        end
        calm = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d queries in %0d bytes, %0d records checked, %0d mismatches",
                 queries_sent, items_sent, records_checked, err_count);
        if (err_count == 0 && token_recs_due.size() == 0) begin
            $display("[search_query_byte_lexer] OK");
        end else begin
            $display("[search_query_byte_lexer] ERROR");
        end
        $finish;
    end

endmodule
